### design/lzbt_pkg.sv
// ----------------------------------------------------------------------------
// lzbt_pkg: shared constants for the binary-tree match finder
// Operation codes, register indexes, sizes and match limits.
// ----------------------------------------------------------------------------
package lzbt_pkg;

  localparam int unsigned DataDepth     = 65536;
  localparam int unsigned WindowDepth   = 65536;
  localparam int unsigned HashDepthBits = 16;
  localparam int unsigned MaxMatches    = 16;

  localparam int unsigned AddrW = $clog2(DataDepth);
  localparam int unsigned SlotW = $clog2(WindowDepth);
  localparam int unsigned PosW  = 17;
  localparam int unsigned LenW  = 9;

  localparam logic [LenW-1:0] MinLen  = 9'd4;
  localparam logic [LenW-1:0] MaxLen  = 9'd273;
  localparam logic [31:0]     HashMul = 32'd2654435761;
  localparam logic [PosW-1:0] PosMax  = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_FIND    = 2'd1,
    OP_SKIP    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_HASH   = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_LENGTH = 2'd3
  } cfg_idx_e;

  // Tree link entry: valid flag and position
  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] pos;
  } link_t;

  // Pointer to a pending child link
  typedef struct packed {
    logic             in_right;
    logic [SlotW-1:0] slot;
  } link_ref_t;

endpackage

### design/lz_binary_tree_match_finder_top.sv
// ----------------------------------------------------------------------------
// lz_binary_tree_match_finder_top: BT4-style match finder
// Holds the byte buffer, the hash root table and the left/right tree links;
// finds and inserts positions with one small sequencer.
// ----------------------------------------------------------------------------
// Operation: a write word stores one byte; a find hashes, walks the tree node by node
//   comparing bytes, and sends its result words; skip does the same per position
//   with at most four nodes. The tree walk and its byte compare set the rate.
// Throughput: one input word at a time; the next word is taken once the last
//   result is in the output register.
// Reset: asynchronous, active low; then a clearing pass over the
//   root and link tables; a restart word runs the same pass over the roots.
// ----------------------------------------------------------------------------
module lz_binary_tree_match_finder_top
  import lzbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [16:0]       cfg_data_i,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [15:0]       write_address_i,
  input  logic [7:0]        write_value_i,
  input  logic [4:0]        match_limit_i,
  input  logic [16:0]       skip_count_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              match_valid_o,
  output logic [15:0]       match_distance_o,
  output logic [8:0]        match_length_o,
  output logic [16:0]       searched_position_o,
  output logic              last_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SKIP, S_H0, S_H1, S_H2, S_H3, S_MOD, S_ROOT,
    S_WALK, S_NODE, S_CMP, S_CMPW, S_DECIDE, S_EMIT_MID, S_BRANCH,
    S_TAIL1, S_TAIL2, S_FIN1, S_FIN2, S_EMIT_END
  } state_e;

  // Storage
  logic [7:0] data_mem  [DataDepth];
  link_t      root_mem  [2**HashDepthBits];
  link_t      left_mem  [WindowDepth];
  link_t      right_mem [WindowDepth];

  // Configuration registers
  logic [16:0] win_q, dl_q;
  logic [4:0]  hb_q;
  logic [9:0]  sd_q;

  // Sequencer state
  state_e            state_q, ret_q;
  logic [15:0]       clr_cnt_q;
  logic              clr_links_q;
  logic [PosW-1:0]   np_q, cur_q, node_q;
  logic [16:0]       cnt_q;
  logic [9:0]        depth_q;
  logic [4:0]        keep_q, n_q;
  logic              is_find_q, have_q;
  logic [7:0]        b0_q, b1_q;
  logic [31:0]       prod_q;
  logic [HashDepthBits-1:0] h_q;
  logic [PosW-1:0]   mod_x_q;
  logic [17:0]       mod_rem_q;
  logic [4:0]        mod_bit_q;
  logic [SlotW-1:0]  ni_q;
  logic [LenW-1:0]   len_q, best_q, len_l_q, len_r_q;
  logic              mism_q, lt_q;
  link_ref_t         lp_q, rp_q;
  link_t             tl_q, tr_q;
  logic [15:0]       pend_dist_q;
  logic [LenW-1:0]   pend_len_q;

  // Output register
  logic              out_valid_q, mv_q, last_q;
  logic [15:0]       dist_q;
  logic [8:0]        olen_q;
  logic [16:0]       spos_q;

  // Memory read data
  logic [7:0] rd0_q, rd1_q;
  link_t      root_rd_q, left_rd_q, right_rd_q;

  // Effective configuration
  logic [16:0]     win_eff, dlen_eff;
  logic [4:0]      hb_eff;
  logic [LenW-1:0] limit;
  logic [16:0]     room;

  always_comb begin
    if (win_q == '0) begin
      win_eff = 17'd1;
    end else if (win_q > 17'(WindowDepth)) begin
      win_eff = 17'(WindowDepth);
    end else begin
      win_eff = win_q;
    end
    dlen_eff = (dl_q > 17'(DataDepth)) ? 17'(DataDepth) : dl_q;
    if (hb_q == '0) begin
      hb_eff = 5'd1;
    end else if (hb_q > 5'(HashDepthBits)) begin
      hb_eff = 5'(HashDepthBits);
    end else begin
      hb_eff = hb_q;
    end
    room  = dlen_eff - cur_q;
    limit = (room > 17'(MaxLen)) ? MaxLen : room[LenW-1:0];
  end

  logic in_acc, out_free, fits_np, out_load;
  logic [HashDepthBits-1:0] h_idx;
  logic [17:0] mod_shift;
  logic [16:0] diff;
  logic [4:0]  keep_in;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  // a result word enters the output register this cycle
  assign out_load  = out_free && (state_q == S_EMIT_MID || state_q == S_EMIT_END);
  assign fits_np   = ({1'b0, np_q} + 18'd4) <= {1'b0, dlen_eff};
  assign h_idx     = HashDepthBits'(prod_q >> (6'd32 - {1'b0, hb_eff}));
  assign mod_shift = {mod_rem_q[16:0], mod_x_q[mod_bit_q]};
  assign diff      = cur_q - node_q;
  assign keep_in   = (match_limit_i > 5'(MaxMatches)) ? 5'(MaxMatches) : match_limit_i;

  // Data buffer: one write port, two registered read ports
  logic              dw_en;
  logic [AddrW-1:0]  ra0, ra1;
  logic [16:0]       a0_full, a1_full;

  assign dw_en = in_acc && (operation_i == OP_WRITE);

  always_comb begin
    a0_full = 17'(cur_q) + 17'(len_q);
    a1_full = 17'(node_q) + 17'(len_q);
    unique case (state_q)
      S_H0: begin
        ra0 = cur_q[AddrW-1:0];
        ra1 = AddrW'(cur_q + 17'd1);
      end
      S_H1: begin
        ra0 = AddrW'(cur_q + 17'd2);
        ra1 = AddrW'(cur_q + 17'd3);
      end
      default: begin
        ra0 = a0_full[AddrW-1:0];
        ra1 = a1_full[AddrW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dw_en) begin
      data_mem[write_address_i] <= write_value_i;
    end
    rd0_q <= data_mem[ra0];
    rd1_q <= data_mem[ra1];
  end

  // Root table and link tables: write ports chosen by state
  logic                     rw_en, lw_en, rw2_en;
  logic [HashDepthBits-1:0] rw_addr;
  link_t                    rw_data;
  logic                     lw_l_en, lw_r_en;
  logic [SlotW-1:0]         lw_l_addr, lw_r_addr;
  link_t                    lw_l_data, lw_r_data;
  link_ref_t                lw_ref;
  link_t                    lw_data;

  always_comb begin
    rw_en     = 1'b0;
    rw_addr   = h_q;
    rw_data   = '{valid: 1'b1, pos: cur_q};
    lw_en     = 1'b0;
    lw_ref    = lp_q;
    lw_data   = '0;
    rw2_en    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        rw_en   = 1'b1;
        rw_addr = clr_cnt_q[HashDepthBits-1:0];
        rw_data = '0;
        rw2_en  = clr_links_q;
      end
      S_ROOT:  begin
        rw_en  = 1'b1;
        rw2_en = 1'b1;
      end
      S_BRANCH: begin
        if (len_q < MaxLen) begin
          lw_en   = 1'b1;
          lw_ref  = (mism_q && lt_q) ? rp_q : lp_q;
          lw_data = '{valid: 1'b1, pos: node_q};
        end
      end
      S_TAIL1: begin
        lw_en   = 1'b1;
        lw_data = tl_q;
      end
      S_TAIL2: begin
        lw_en   = 1'b1;
        lw_ref  = rp_q;
        lw_data = tr_q;
      end
      S_FIN1:  lw_en = 1'b1;
      S_FIN2: begin
        lw_en  = 1'b1;
        lw_ref = rp_q;
      end
      default: ;
    endcase
    // rw2_en writes both child links empty, at the new slot or the sweep index
    lw_l_en   = rw2_en || (lw_en && !lw_ref.in_right);
    lw_r_en   = rw2_en || (lw_en && lw_ref.in_right);
    lw_l_addr = lw_ref.slot;
    lw_r_addr = lw_ref.slot;
    lw_l_data = lw_data;
    lw_r_data = lw_data;
    if (rw2_en) begin
      lw_l_addr = (state_q == S_CLEAR) ? clr_cnt_q[SlotW-1:0] : mod_rem_q[SlotW-1:0];
      lw_r_addr = lw_l_addr;
      lw_l_data = '0;
      lw_r_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      root_mem[rw_addr] <= rw_data;
    end
    root_rd_q <= root_mem[h_q];
  end

  always_ff @(posedge clk_i) begin
    if (lw_l_en) begin
      left_mem[lw_l_addr] <= lw_l_data;
    end
    left_rd_q <= left_mem[ni_q];
  end

  always_ff @(posedge clk_i) begin
    if (lw_r_en) begin
      right_mem[lw_r_addr] <= lw_r_data;
    end
    right_rd_q <= right_mem[ni_q];
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 17'd65536;
      hb_q  <= 5'd16;
      sd_q  <= 10'd32;
      dl_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW: win_q <= cfg_data_i;
        CFG_HASH:   hb_q  <= cfg_data_i[4:0];
        CFG_DEPTH:  sd_q  <= cfg_data_i[9:0];
        CFG_LENGTH: dl_q  <= cfg_data_i;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      clr_cnt_q   <= '0;
      clr_links_q <= 1'b1;
      np_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 16'd1;
          if (&clr_cnt_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (op_e'(operation_i))
              OP_WRITE: ;
              OP_FIND: begin
                cur_q     <= np_q;
                keep_q    <= keep_in;
                n_q       <= '0;
                is_find_q <= 1'b1;
                depth_q   <= sd_q;
                if (np_q < PosMax) begin
                  np_q <= np_q + 17'd1;
                end
                state_q <= fits_np ? S_H0 : S_EMIT_END;
              end
              OP_SKIP: begin
                cnt_q   <= skip_count_i;
                state_q <= S_SKIP;
              end
              OP_RESTART: begin
                clr_links_q <= 1'b0;
                clr_cnt_q   <= '0;
                state_q     <= S_CLEAR;
              end
            endcase
          end
        end
        S_SKIP: begin
          if (cnt_q != '0 && np_q < dlen_eff) begin
            cnt_q     <= cnt_q - 17'd1;
            cur_q     <= np_q;
            np_q      <= np_q + 17'd1;
            keep_q    <= '0;
            n_q       <= '0;
            is_find_q <= 1'b0;
            depth_q   <= 10'd4;
            if (fits_np) begin
              state_q <= S_H0;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_H0: state_q <= S_H1;
        S_H1: begin
          b0_q    <= rd0_q;
          b1_q    <= rd1_q;
          state_q <= S_H2;
        end
        S_H2: begin
          prod_q  <= 32'({rd1_q, rd0_q, b1_q, b0_q} * HashMul);
          state_q <= S_H3;
        end
        S_H3: begin
          h_q       <= h_idx;
          mod_x_q   <= cur_q;
          mod_rem_q <= '0;
          mod_bit_q <= 5'd16;
          ret_q     <= S_ROOT;
          state_q   <= S_MOD;
        end
        S_MOD: begin
          // restoring remainder, one bit a cycle
          if (mod_shift >= {1'b0, win_eff}) begin
            mod_rem_q <= mod_shift - {1'b0, win_eff};
          end else begin
            mod_rem_q <= mod_shift;
          end
          mod_bit_q <= mod_bit_q - 5'd1;
          if (mod_bit_q == '0) begin
            state_q <= ret_q;
          end
        end
        S_ROOT: begin
          have_q  <= root_rd_q.valid;
          node_q  <= root_rd_q.pos;
          lp_q    <= '{in_right: 1'b0, slot: mod_rem_q[SlotW-1:0]};
          rp_q    <= '{in_right: 1'b1, slot: mod_rem_q[SlotW-1:0]};
          best_q  <= MinLen - 9'd1;
          len_l_q <= '0;
          len_r_q <= '0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (!have_q || depth_q == '0) begin
            state_q <= S_FIN1;
          end else begin
            depth_q <= depth_q - 10'd1;
            if (node_q >= cur_q || diff >= win_eff) begin
              state_q <= S_FIN1;
            end else begin
              mod_x_q   <= node_q;
              mod_rem_q <= '0;
              mod_bit_q <= 5'd16;
              ret_q     <= S_NODE;
              state_q   <= S_MOD;
            end
          end
        end
        S_NODE: begin
          ni_q    <= mod_rem_q[SlotW-1:0];
          len_q   <= (len_l_q < len_r_q) ? len_l_q : len_r_q;
          mism_q  <= 1'b0;
          lt_q    <= 1'b0;
          state_q <= S_CMP;
        end
        S_CMP: state_q <= (len_q < limit) ? S_CMPW : S_DECIDE;
        S_CMPW: begin
          if (rd0_q == rd1_q) begin
            len_q   <= len_q + 9'd1;
            state_q <= S_CMP;
          end else begin
            mism_q  <= 1'b1;
            lt_q    <= rd0_q < rd1_q;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // link read data for ni_q has settled by now
          tl_q <= left_rd_q;
          tr_q <= right_rd_q;
          if (len_q > best_q && n_q < keep_q && n_q != '0) begin
            state_q <= S_EMIT_MID;
          end else begin
            if (len_q > best_q) begin
              best_q <= len_q;
              if (n_q < keep_q) begin
                pend_dist_q <= diff[15:0];
                pend_len_q  <= len_q;
                n_q         <= n_q + 5'd1;
              end
            end
            state_q <= S_BRANCH;
          end
        end
        S_EMIT_MID: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            mv_q        <= 1'b1;
            dist_q      <= pend_dist_q;
            olen_q      <= pend_len_q;
            spos_q      <= cur_q;
            last_q      <= 1'b0;
            pend_dist_q <= diff[15:0];
            pend_len_q  <= len_q;
            n_q         <= n_q + 5'd1;
            best_q      <= len_q;
            state_q     <= S_BRANCH;
          end
        end
        S_BRANCH: begin
          if (len_q >= MaxLen) begin
            state_q <= S_TAIL1;
          end else if (mism_q && lt_q) begin
            rp_q    <= '{in_right: 1'b0, slot: ni_q};
            have_q  <= tl_q.valid;
            node_q  <= tl_q.pos;
            len_r_q <= len_q;
            state_q <= S_WALK;
          end else begin
            lp_q    <= '{in_right: 1'b1, slot: ni_q};
            have_q  <= tr_q.valid;
            node_q  <= tr_q.pos;
            len_l_q <= len_q;
            state_q <= S_WALK;
          end
        end
        S_TAIL1: state_q <= S_TAIL2;
        S_TAIL2: state_q <= is_find_q ? S_EMIT_END : S_SKIP;
        S_FIN1:  state_q <= S_FIN2;
        S_FIN2:  state_q <= is_find_q ? S_EMIT_END : S_SKIP;
        S_EMIT_END: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            mv_q        <= (n_q != '0);
            dist_q      <= (n_q != '0) ? pend_dist_q : '0;
            olen_q      <= (n_q != '0) ? pend_len_q : '0;
            spos_q      <= cur_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign match_valid_o       = mv_q;
  assign match_distance_o    = dist_q;
  assign match_length_o      = olen_q;
  assign searched_position_o = spos_q;
  assign last_o              = last_q;

endmodule

### design/lzbt_checker.sv
// ----------------------------------------------------------------------------
// lzbt_checker: port-level checks for the match finder
// Watches the result channel and the clearing pass after reset.
// ----------------------------------------------------------------------------
module lzbt_checker
  import lzbt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        match_valid_o,
  input logic [15:0] match_distance_o,
  input logic [8:0]  match_length_o,
  input logic        last_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_length_o))
    else $error("result word dropped while stalled");

  // an empty result is the only word of its find
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_valid_o |-> last_o && match_length_o == '0 &&
      match_distance_o == '0)
    else $error("empty result malformed");

  // reported lengths stay in range and distance is nonzero
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_valid_o |-> match_length_o >= MinLen &&
      match_length_o <= MaxLen && match_distance_o != '0)
    else $error("match length or distance out of range");

  // input is held off right after reset, as the tables start to be swept
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input taken during clearing pass");

endmodule

bind lz_binary_tree_match_finder_top lzbt_checker u_lzbt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .match_valid_o    (match_valid_o),
  .match_distance_o (match_distance_o),
  .match_length_o   (match_length_o),
  .last_o           (last_o)
);
